@@ rtl/bqeq_pkg.sv @@
// ----------------------------------------------------------------------------
// bqeq_pkg: shared types and constants of the beat quantizing event queue
// command and result formats passed between the front, the queues and the back
// ----------------------------------------------------------------------------
package bqeq_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int FRAME_W   = 16;
    localparam int POS_W     = 48;
    localparam int FRAC_W    = 16;
    localparam int BEAT_W    = POS_W - FRAC_W + 1;
    localparam int SUM_W     = POS_W + 1;

    // input action codes
    localparam logic [1:0] ACT_EVENT = 2'd0;
    localparam logic [1:0] ACT_SPEED = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // quantize mode codes
    localparam logic [1:0] QM_FLOOR1 = 2'd0;
    localparam logic [1:0] QM_ROUND1 = 2'd1;
    localparam logic [1:0] QM_CEIL   = 2'd2;

    // rounding biases in Q32.16, one beat folded in where the target adds one
    localparam logic [SUM_W-1:0] ONE_BEAT   = SUM_W'(32'h0001_0000);
    localparam logic [SUM_W-1:0] HALF_BEAT  = SUM_W'(32'h0000_8000);
    localparam logic [SUM_W-1:0] BIAS_FLOOR = ONE_BEAT;
    localparam logic [SUM_W-1:0] BIAS_ROUND = ONE_BEAT + HALF_BEAT;
    localparam logic [SUM_W-1:0] BIAS_CEIL  = ONE_BEAT - SUM_W'(1);

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_ENQ,
        CMD_DRAIN,
        CMD_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [PAYLOAD_W-1:0]  payload;
        logic [FRAME_W-1:0]    frame;
        logic [BEAT_W-1:0]     beat;
    } cmd_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0]  payload;
        logic [FRAME_W-1:0]    frame;
        logic                  last;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_RELEASE
    } back_state_t;

endpackage

@@ rtl/beat_quantizing_event_queue.sv @@
// ----------------------------------------------------------------------------
// beat_quantizing_event_queue: holds musical events until a beat boundary
// front classifier, command queue, event ring sequencer and result queue
// ----------------------------------------------------------------------------
// the block takes one input beat per cycle while its command queue has room:
// an event (action 0), a transport speed update (action 1) or a beat position
// tick (action 2). while the transport rolls, events are stored with a whole
// target beat chosen by quantize_mode (floor plus one, round-half-up plus one
// or ceiling of the Q32.16 position); a full ring of QUEUE_DEPTH entries drops
// new events. a tick releases stored events in order while the head target is
// at or below the tick position, a stop releases all of them, and a stopped
// transport passes events straight through. released events carry the frame
// of the item that released them, out_last marks the final result of an item.
// the back sequencer releases the entries of a tick or stop one entry per
// cycle while the result queue has room, from the registered ring read port.
// a stalled result side only holds up the back; the front keeps accepting
// until the two-entry command queue fills. the user must write quantize_mode
// only while the block is idle; the block itself does not enforce this.
module beat_quantizing_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    // input beats
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [31:0] event_payload,
    input  logic [15:0] frame_offset,
    input  logic [47:0] beat_pos,
    input  logic        speed_positive,
    // result beats
    output logic        empty,
    input  logic        pop,
    output logic [31:0] out_payload,
    output logic [15:0] out_frame,
    output logic        out_last
);

    localparam int CMD_W = $bits(bqeq_pkg::cmd_t);
    localparam int RES_W = $bits(bqeq_pkg::result_t);

    logic              in_take;
    logic              cmd_push;
    bqeq_pkg::cmd_t    cmd_in;
    logic [CMD_W-1:0]  cmd_rd_bits;
    bqeq_pkg::cmd_t    cmd_out;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_push;
    bqeq_pkg::result_t res_in;
    logic              res_full;
    logic [RES_W-1:0]  res_rd_bits;
    bqeq_pkg::result_t res_out;

    // an input beat is taken whenever the command queue has room
    assign in_take = push && !full;

    bqeq_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_take        (in_take),
        .action         (action),
        .event_payload  (event_payload),
        .frame_offset   (frame_offset),
        .beat_pos       (beat_pos),
        .speed_positive (speed_positive),
        .cmd_push       (cmd_push),
        .cmd            (cmd_in)
    );

    // commands from front to back
    bqeq_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd_bits),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_rd_bits;

    bqeq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result beats wait here, so a stalled consumer holds up the back first
    bqeq_fifo #(
        .WIDTH (RES_W)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_bits),
        .empty   (empty)
    );

    assign res_out     = res_rd_bits;
    assign out_payload = res_out.payload;
    assign out_frame   = res_out.frame;
    assign out_last    = res_out.last;

endmodule

@@ rtl/bqeq_fifo.sv @@
// ----------------------------------------------------------------------------
// bqeq_fifo: two-entry queue
// decouples a producer and a consumer, full and empty flags from a fill count
// ----------------------------------------------------------------------------
module bqeq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] entries_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/bqeq_front.sv @@
// ----------------------------------------------------------------------------
// bqeq_front: input classifier
// tracks transport and mode; an event, tick or stop makes a back-end command
// ----------------------------------------------------------------------------
module bqeq_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_wr_data,
    input  logic                            in_take,
    input  logic [1:0]                      action,
    input  logic [bqeq_pkg::PAYLOAD_W-1:0]  event_payload,
    input  logic [bqeq_pkg::FRAME_W-1:0]    frame_offset,
    input  logic [bqeq_pkg::POS_W-1:0]      beat_pos,
    input  logic                            speed_positive,
    output logic                            cmd_push,
    output bqeq_pkg::cmd_t                  cmd
);

    logic [1:0]                     mode_reg;
    logic                           rolling_reg;
    logic                           rolling_next;
    logic [bqeq_pkg::SUM_W-1:0]     bias;
    logic [bqeq_pkg::SUM_W-1:0]     biased_pos;
    logic [bqeq_pkg::BEAT_W-1:0]    target;

    // target beat = floor((pos + bias) / one beat), one add for every mode
    always_comb
    begin
        case (mode_reg)
            bqeq_pkg::QM_ROUND1: bias = bqeq_pkg::BIAS_ROUND;
            bqeq_pkg::QM_CEIL:   bias = bqeq_pkg::BIAS_CEIL;
            default:             bias = bqeq_pkg::BIAS_FLOOR;
        endcase
        biased_pos = {1'b0, beat_pos} + bias;
        target     = biased_pos[bqeq_pkg::SUM_W-1:bqeq_pkg::FRAC_W];
    end

    always_comb
    begin
        cmd_push     = 1'b0;
        rolling_next = rolling_reg;
        cmd.op       = bqeq_pkg::CMD_PASS;
        cmd.payload  = event_payload;
        cmd.frame    = frame_offset;
        cmd.beat     = target;
        if (in_take)
        begin
            case (action)
                bqeq_pkg::ACT_EVENT:
                begin
                    cmd_push = 1'b1;
                    cmd.op   = rolling_reg ? bqeq_pkg::CMD_ENQ : bqeq_pkg::CMD_PASS;
                end
                bqeq_pkg::ACT_SPEED:
                begin
                    rolling_next = speed_positive;
                    cmd_push     = !speed_positive;
                    cmd.op       = bqeq_pkg::CMD_DRAIN;
                end
                bqeq_pkg::ACT_TICK:
                begin
                    cmd_push = 1'b1;
                    cmd.op   = bqeq_pkg::CMD_TICK;
                    // whole beats of the position, compared against targets
                    cmd.beat = {1'b0, beat_pos[bqeq_pkg::POS_W-1:bqeq_pkg::FRAC_W]};
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= bqeq_pkg::QM_FLOOR1;
            rolling_reg <= 1'b0;
        end
        else
        begin
            rolling_reg <= rolling_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

endmodule

@@ rtl/bqeq_back.sv @@
// ----------------------------------------------------------------------------
// bqeq_back: event store and release sequencer
// holds quantized events; with result room, due ones leave one per cycle
// ----------------------------------------------------------------------------
module bqeq_back #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  bqeq_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output bqeq_pkg::result_t res
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [bqeq_pkg::PAYLOAD_W-1:0] payload_mem [QUEUE_DEPTH];
    logic [bqeq_pkg::BEAT_W-1:0]    target_mem  [QUEUE_DEPTH];

    bqeq_pkg::back_state_t          state_reg;
    bqeq_pkg::back_state_t          state_next;
    logic [IDX_W-1:0]               head_reg;
    logic [IDX_W-1:0]               head_next;
    logic [IDX_W-1:0]               tail_reg;
    logic [IDX_W-1:0]               tail_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           all_reg;
    logic [bqeq_pkg::BEAT_W-1:0]    bound_reg;
    logic [bqeq_pkg::FRAME_W-1:0]   frame_reg;
    logic                           pend_valid_reg;
    logic [bqeq_pkg::PAYLOAD_W-1:0] pend_payload_reg;
    logic [bqeq_pkg::PAYLOAD_W-1:0] rd_payload_reg;
    logic [bqeq_pkg::BEAT_W-1:0]    rd_target_reg;

    logic head_avail;
    logic mem_we;
    logic head_adv;
    logic pend_load;
    logic pend_clear;
    logic rel_start;
    logic rel_done;

    // head entry is registered read data of the current head slot
    assign head_avail = (count_reg != '0) && (all_reg || (rd_target_reg <= bound_reg));

    // output decode
    always_comb
    begin
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '{payload: pend_payload_reg, frame: frame_reg, last: 1'b0};
        mem_we     = 1'b0;
        head_adv   = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        rel_start  = 1'b0;
        rel_done   = 1'b0;
        case (state_reg)
            bqeq_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        bqeq_pkg::CMD_PASS:
                        begin
                            if (!res_full)
                            begin
                                res_push = 1'b1;
                                res      = '{payload: cmd.payload, frame: cmd.frame,
                                             last: 1'b1};
                                cmd_pop  = 1'b1;
                            end
                        end
                        bqeq_pkg::CMD_ENQ:
                        begin
                            cmd_pop = 1'b1;
                            // full queue drops the event
                            mem_we  = (count_reg < CNT_W'(QUEUE_DEPTH));
                        end
                        default:
                        begin
                            cmd_pop   = 1'b1;
                            rel_start = 1'b1;
                        end
                    endcase
                end
            end
            bqeq_pkg::BK_RELEASE:
            begin
                if (head_avail)
                begin
                    // hold one entry back so the final one can be marked last
                    if (!pend_valid_reg)
                    begin
                        head_adv  = 1'b1;
                        pend_load = 1'b1;
                    end
                    else if (!res_full)
                    begin
                        res_push  = 1'b1;
                        head_adv  = 1'b1;
                        pend_load = 1'b1;
                    end
                end
                else if (pend_valid_reg)
                begin
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        res.last   = 1'b1;
                        pend_clear = 1'b1;
                        rel_done   = 1'b1;
                    end
                end
                else
                begin
                    rel_done = 1'b1;
                end
            end
            default:
            begin
                rel_done = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bqeq_pkg::BK_IDLE:
            begin
                if (rel_start)
                begin
                    state_next = bqeq_pkg::BK_RELEASE;
                end
            end
            bqeq_pkg::BK_RELEASE:
            begin
                if (rel_done)
                begin
                    state_next = bqeq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bqeq_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (head_adv)
        begin
            head_next = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
        end
        if (mem_we)
        begin
            tail_next = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + IDX_W'(1);
        end
        count_next = count_reg + CNT_W'(mem_we) - CNT_W'(head_adv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bqeq_pkg::BK_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rel_start)
        begin
            all_reg   <= (cmd.op == bqeq_pkg::CMD_DRAIN);
            bound_reg <= cmd.beat;
            frame_reg <= cmd.frame;
        end
        if (pend_load)
        begin
            pend_payload_reg <= rd_payload_reg;
        end
    end

    // event ring, read at the upcoming head every cycle, write-first on a hit
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[tail_reg] <= cmd.payload;
            target_mem[tail_reg]  <= cmd.beat;
        end
        if (mem_we && (tail_reg == head_next))
        begin
            rd_payload_reg <= cmd.payload;
            rd_target_reg  <= cmd.beat;
        end
        else
        begin
            rd_payload_reg <= payload_mem[head_next];
            rd_target_reg  <= target_mem[head_next];
        end
    end

endmodule

@@ tb/tb_beat_quantizing_event_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_beat_quantizing_event_queue: self-checking bench of the event quantizer
// a directed table and random transport sequences are pushed into the block,
// a shadow of the event ring predicts every released event, and each popped
// beat is checked field by field against the oldest awaited event
// ----------------------------------------------------------------------------
module tb_beat_quantizing_event_queue;

    localparam int          DEPTH       = 64;
    localparam int          LIMIT_CYCLES = 600000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE_TAIL = 12;
    localparam logic [1:0]  ACT_NONE    = 2'd3;    // unused action code
    localparam logic [1:0]  MODE_SPARE  = 2'd3;    // unused mode, acts as floor
    localparam logic [47:0] POS_MAX     = 48'hFFFF_FFFF_FFFF;

    // one input item as seen by the shadow
    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] payload;
        logic [15:0] frame;
        logic [47:0] pos;
        logic        speed;
    } quant_item_t;

    // one row of the directed table, with an optional typed-in result
    typedef struct packed {
        logic [1:0]  mode;
        quant_item_t it;
        logic        lit;
        logic [31:0] lit_payload;
        logic [15:0] lit_frame;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = bqeq_pkg::QM_FLOOR1;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = bqeq_pkg::ACT_EVENT;
    logic [31:0] event_payload = '0;
    logic [15:0] frame_offset = '0;
    logic [47:0] beat_pos = '0;
    logic        speed_positive = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] out_payload;
    logic [15:0] out_frame;
    logic        out_last;

    // shadow of the event ring and transport
    logic [31:0] ring_payload [DEPTH];
    logic [32:0] ring_beat [DEPTH];
    logic [5:0]  ring_head = '0;
    logic [5:0]  ring_tail = '0;
    int          ring_count = 0;
    logic        rolling = 1'b0;
    logic [1:0]  mode_shadow = bqeq_pkg::QM_FLOOR1;

    bqeq_pkg::result_t released_now[$];      // events released by the item just accepted
    bqeq_pkg::result_t awaited_events[$];    // events still to come out, oldest first
    table_row_t        directed[$];

    int          fault_count = 0;
    int          cycle_count = 0;
    int          idle_pct = 25;        // chance of a sender gap after a beat
    bit          steady = 1'b0;        // no idling on either side
    bit          hold_req = 1'b0;      // asks the receiver for a long hold-off
    int          hold_left = 0;
    int          rx_gap = 0;
    int          wait_cnt;

    beat_quantizing_event_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .push           (push),
        .full           (full),
        .action         (action),
        .event_payload  (event_payload),
        .frame_offset   (frame_offset),
        .beat_pos       (beat_pos),
        .speed_positive (speed_positive),
        .empty          (empty),
        .pop            (pop),
        .out_payload    (out_payload),
        .out_frame      (out_frame),
        .out_last       (out_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: no progress within %0d cycles", $time, LIMIT_CYCLES);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic quant_item_t mk_item(input logic [1:0] act, input logic [31:0] payload,
                                            input logic [15:0] frame, input logic [47:0] pos,
                                            input logic speed);
        quant_item_t it;
        it.act     = act;
        it.payload = payload;
        it.frame   = frame;
        it.pos     = pos;
        it.speed   = speed;
        return it;
    endfunction

    function automatic table_row_t mk_row(input logic [1:0] mode, input quant_item_t it,
                                          input logic lit, input logic [31:0] lit_payload,
                                          input logic [15:0] lit_frame);
        table_row_t r;
        r.mode        = mode;
        r.it          = it;
        r.lit         = lit;
        r.lit_payload = lit_payload;
        r.lit_frame   = lit_frame;
        return r;
    endfunction

    // whole target beat of an event queued at pos
    function automatic logic [32:0] quantize_target(input logic [1:0] mode,
                                                    input logic [47:0] pos);
        logic [48:0] sum;
        logic [32:0] beat;
        case (mode)
            bqeq_pkg::QM_ROUND1:
            begin
                sum  = {1'b0, pos} + 49'h0_8000;
                beat = sum[48:16] + 33'd1;
            end
            bqeq_pkg::QM_CEIL:
            begin
                sum  = {1'b0, pos} + 49'h0_FFFF;
                beat = sum[48:16];
            end
            default:
                beat = {1'b0, pos[47:16]} + 33'd1;
        endcase
        return beat;
    endfunction

    // pops the ring head while due at pos, or everything on a stop
    task automatic drain_due(input logic drain_all, input logic [47:0] pos,
                             input logic [15:0] frame);
        bqeq_pkg::result_t r;
        while (ring_count > 0)
        begin
            if (!drain_all && {ring_beat[ring_head], 16'h0} > {1'b0, pos})
                break;
            r.payload = ring_payload[ring_head];
            r.frame   = frame;
            r.last    = 1'b0;
            released_now.push_back(r);
            ring_head  = ring_head + 6'd1;
            ring_count = ring_count - 1;
        end
        if (released_now.size() > 0)
            released_now[released_now.size() - 1].last = 1'b1;
    endtask

    // advances the shadow by one accepted item, results go to released_now
    task automatic quantize_and_release(input quant_item_t it);
        bqeq_pkg::result_t r;
        released_now.delete();
        case (it.act)
            bqeq_pkg::ACT_EVENT:
            begin
                if (!rolling)
                begin
                    // stopped transport: straight through
                    r.payload = it.payload;
                    r.frame   = it.frame;
                    r.last    = 1'b1;
                    released_now.push_back(r);
                end
                else if (ring_count < DEPTH)
                begin
                    ring_payload[ring_tail] = it.payload;
                    ring_beat[ring_tail]    = quantize_target(mode_shadow, it.pos);
                    ring_tail  = ring_tail + 6'd1;
                    ring_count = ring_count + 1;
                end
                // a full ring drops the event silently
            end
            bqeq_pkg::ACT_SPEED:
            begin
                rolling = it.speed;
                if (!rolling)
                    drain_due(1'b1, it.pos, it.frame);
            end
            bqeq_pkg::ACT_TICK:
                drain_due(1'b0, it.pos, it.frame);
            default:
                ;
        endcase
    endtask

    task automatic note_fault(input string what, input logic [31:0] expd,
                              input logic [31:0] got);
        fault_count++;
        $display("%0t: %s expected %h got %h", $time, what, expd, got);
    endtask

    // offers one item, waits for its beat, then records what it releases
    task automatic offer(input quant_item_t it, input logic lit, input logic [31:0] lit_payload,
                         input logic [15:0] lit_frame);
        bqeq_pkg::result_t r;
        action         <= it.act;
        event_payload  <= it.payload;
        frame_offset   <= it.frame;
        beat_pos       <= it.pos;
        speed_positive <= it.speed;
        push           <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        quantize_and_release(it);
        if (lit)
        begin
            // typed-in row: the shadow still moves, the literal is what we expect
            r.payload = lit_payload;
            r.frame   = lit_frame;
            r.last    = 1'b1;
            awaited_events.push_back(r);
        end
        else
        begin
            foreach (released_now[i])
                awaited_events.push_back(released_now[i]);
        end
        if (!steady && $urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
    endtask

    // sender pause until every awaited event is out and the back has gone quiet
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TAIL)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = mode;
    endtask

    // random transport sessions: start, events around the cursor, ticks that
    // move forward, then a far tick or a stop; a fifth of the time pure noise
    task automatic random_phase(input logic [1:0] mode, input int n_items, input int gap_pct);
        int          done;
        int          k;
        logic [47:0] cursor;
        logic [47:0] pos;
        quant_item_t it;
        settle();
        write_mode(mode);
        idle_pct = gap_pct;
        done = 0;
        while (done < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                pos = 48'({$urandom, $urandom});
                it = mk_item(2'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 65535)),
                             pos, 1'($urandom_range(0, 1)));
                offer(it, 1'b0, '0, '0);
                if (it.act != ACT_NONE)
                    done++;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       cursor = 48'({$urandom, $urandom});
                    1:       cursor = POS_MAX - 48'($urandom_range(0, 'h40000));
                    default: cursor = 48'($urandom_range(0, 'h7F_FFFF));
                endcase
                offer(mk_item(bqeq_pkg::ACT_SPEED, $urandom, 16'($urandom_range(0, 65535)),
                              cursor, 1'b1), 1'b0, '0, '0);
                done++;
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    pos = cursor + 48'($urandom_range(0, 'h2FFFF));
                    offer(mk_item(bqeq_pkg::ACT_EVENT, $urandom, 16'($urandom_range(0, 65535)),
                                  pos, 1'($urandom_range(0, 1))), 1'b0, '0, '0);
                    done++;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        cursor = cursor + 48'($urandom_range(0, 'h18000));
                        offer(mk_item(bqeq_pkg::ACT_TICK, $urandom,
                                      16'($urandom_range(0, 65535)), cursor,
                                      1'($urandom_range(0, 1))), 1'b0, '0, '0);
                        done++;
                    end
                end
                if ($urandom_range(0, 1) == 0)
                    it = mk_item(bqeq_pkg::ACT_TICK, $urandom, 16'($urandom_range(0, 65535)),
                                 cursor + 48'($urandom_range('h10000, 'h40000)), 1'b1);
                else
                    it = mk_item(bqeq_pkg::ACT_SPEED, $urandom, 16'($urandom_range(0, 65535)),
                                 cursor, 1'b0);
                offer(it, 1'b0, '0, '0);
                done++;
            end
        end
    endtask

    // receiver holds off for a long stretch while the ring fills past full,
    // a tick dumps the whole ring and pass-through events back up the input
    task automatic fill_and_stall();
        int i;
        settle();
        write_mode(bqeq_pkg::QM_FLOOR1);
        idle_pct = 0;
        hold_req = 1'b1;
        offer(mk_item(bqeq_pkg::ACT_SPEED, $urandom, 16'h0010, 48'h0, 1'b0), 1'b0, '0, '0);
        offer(mk_item(bqeq_pkg::ACT_SPEED, $urandom, 16'h0011, 48'h0, 1'b1), 1'b0, '0, '0);
        for (i = 0; i < DEPTH + 1; i++)
            offer(mk_item(bqeq_pkg::ACT_EVENT, $urandom, 16'($urandom_range(0, 65535)),
                          48'(i) << 14, 1'b1), 1'b0, '0, '0);
        offer(mk_item(bqeq_pkg::ACT_TICK, $urandom, 16'h0012, POS_MAX, 1'b1), 1'b0, '0, '0);
        offer(mk_item(bqeq_pkg::ACT_SPEED, $urandom, 16'h0013, 48'h0, 1'b0), 1'b0, '0, '0);
        for (i = 0; i < 2; i++)
            offer(mk_item(bqeq_pkg::ACT_EVENT, $urandom, 16'($urandom_range(0, 65535)),
                          48'($urandom), 1'b0), 1'b0, '0, '0);
    endtask

    // result side: check the beat taken at this edge, then choose the next pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (awaited_events.size() == 0)
            begin
                fault_count++;
                $display("%0t: result expected none got payload %h frame %h last %b",
                         $time, out_payload, out_frame, out_last);
            end
            else
            begin
                if (out_payload !== awaited_events[0].payload)
                    note_fault("out_payload", awaited_events[0].payload, out_payload);
                if (out_frame !== awaited_events[0].frame)
                    note_fault("out_frame", 32'(awaited_events[0].frame), 32'(out_frame));
                if (out_last !== awaited_events[0].last)
                    note_fault("out_last", 32'(awaited_events[0].last), 32'(out_last));
                void'(awaited_events.pop_front());
            end
        end

        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            pop <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 7) == 0)
        begin
            // random stall burst on the result side, starting with this one
            rx_gap = $urandom_range(0, 9);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    initial
    begin
        // stopped transport: extremes pass straight through
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'h0000_0000, 16'h0000, 48'h0, 1'b0),
            1'b1, 32'h0000_0000, 16'h0000));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'hFFFF_FFFF, 16'hFFFF, POS_MAX, 1'b1),
            1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        // tick while stopped, unused action, stop with nothing queued
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0001, POS_MAX, 1'b0), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, POS_MAX, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0002, 48'h0, 1'b0), 1'b0, '0, '0));
        // start rolling, then a second speed update while already rolling
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0003, 48'h0, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0004, 48'h0, 1'b1), 1'b0, '0, '0));
        // floor plus one: targets 1, 2 and the largest beat that never comes due
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'h1111_1111, 16'h0005, 48'h0, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'h2222_2222, 16'h0006, 48'h1_8000, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'h3333_3333, 16'h0007, POS_MAX, 1'b1),
            1'b0, '0, '0));
        // one step short of beat 1, then exactly on it
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0008, 48'h0_FFFF, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0100, 48'h1_0000, 1'b1),
            1'b1, 32'h1111_1111, 16'h0100));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0200, POS_MAX, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'h4444_4444, 16'h0009, 48'h5_0000, 1'b1),
            1'b0, '0, '0));
        // stop drains both, including the never-due entry
        directed.push_back(mk_row(bqeq_pkg::QM_FLOOR1,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0300, 48'h0, 1'b0), 1'b0, '0, '0));
        // round half up plus one, head-of-line entry blocks an earlier target
        directed.push_back(mk_row(bqeq_pkg::QM_ROUND1,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0010, 48'h0, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_ROUND1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'hA1A1_A1A1, 16'h0011, 48'h0_8000, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_ROUND1,
            mk_item(bqeq_pkg::ACT_EVENT, 32'hA2A2_A2A2, 16'h0012, 48'h0_7FFF, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_ROUND1,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0013, 48'h1_0000, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_ROUND1,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0014, 48'h2_0000, 1'b1), 1'b0, '0, '0));
        // ceiling: a whole position stays put, one step past it rounds up
        directed.push_back(mk_row(bqeq_pkg::QM_CEIL,
            mk_item(bqeq_pkg::ACT_EVENT, 32'hC1C1_C1C1, 16'h0020, 48'h1_0000, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_CEIL,
            mk_item(bqeq_pkg::ACT_EVENT, 32'hC2C2_C2C2, 16'h0021, 48'h1_0001, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_CEIL,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0022, 48'h1_0000, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(bqeq_pkg::QM_CEIL,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0023, 48'h1_0000, 1'b0), 1'b0, '0, '0));
        // unused mode behaves as floor plus one
        directed.push_back(mk_row(MODE_SPARE,
            mk_item(bqeq_pkg::ACT_SPEED, 32'h0, 16'h0030, 48'h0, 1'b1), 1'b0, '0, '0));
        directed.push_back(mk_row(MODE_SPARE,
            mk_item(bqeq_pkg::ACT_EVENT, 32'hD1D1_D1D1, 16'h0031, 48'h0, 1'b1),
            1'b0, '0, '0));
        directed.push_back(mk_row(MODE_SPARE,
            mk_item(bqeq_pkg::ACT_TICK, 32'h0, 16'h0032, 48'h1_0000, 1'b1), 1'b0, '0, '0));

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk, mode rewritten whenever the table switches groups
        foreach (directed[i])
        begin
            if (i == 0 || directed[i].mode != mode_shadow)
            begin
                settle();
                write_mode(directed[i].mode);
            end
            offer(directed[i].it, directed[i].lit, directed[i].lit_payload,
                  directed[i].lit_frame);
        end

        random_phase(bqeq_pkg::QM_CEIL, 6, 30);
        random_phase(MODE_SPARE, 5, 40);
        fill_and_stall();
        steady = 1'b1;
        random_phase(2'($urandom_range(0, 3)), 6, 0);

        // drain what is still in flight
        push <= 1'b0;
        wait_cnt = 0;
        while (awaited_events.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (4 * SETTLE_TAIL)
            @(posedge clk);
        if (awaited_events.size() != 0)
        begin
            fault_count++;
            $display("%0t: %0d events expected but never popped, next payload %h",
                     $time, awaited_events.size(), awaited_events[0].payload);
        end

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bqeq_pkg.sv
rtl/bqeq_fifo.sv
rtl/bqeq_front.sv
rtl/bqeq_back.sv
rtl/beat_quantizing_event_queue.sv
tb/tb_beat_quantizing_event_queue.sv
